>>> sv/suspicious_frame_detector_unit_defines.svh
// Assertion macros for the suspicious frame detector.
`ifndef SUSPICIOUS_FRAME_DETECTOR_UNIT_DEFINES_SVH
`define SUSPICIOUS_FRAME_DETECTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/sfd_pkg.sv
package sfd_pkg;

  localparam int DimW        = 13;
  localparam int MaxDim      = 4096;
  localparam int GridRows    = 24;
  localparam int GridCols    = 48;
  localparam int StripCols   = 96;
  localparam int StripMinH   = 24;
  localparam int StripMinW   = 48;
  localparam int StripMinTop = 10;
  localparam int StepW       = 8;
  localparam int LumaW       = 18;
  // reciprocal of 3 scaled by 2^13, exact for the divisions used here on values below 8192
  localparam int RecipDiv    = 2731;
  localparam logic [31:0] VarLimitScaled = 32'd12000000;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_DARK   = 2'd2;

  typedef logic [2:0] mul_op_t;
  localparam mul_op_t MUL_NONE = 3'd0;
  localparam mul_op_t MUL_LL   = 3'd1;
  localparam mul_op_t MUL_NLO  = 3'd2;
  localparam mul_op_t MUL_NHI  = 3'd3;
  localparam mul_op_t MUL_NN   = 3'd4;
  localparam mul_op_t MUL_NK   = 3'd5;

  typedef struct packed {
    logic    pix_accept;
    logic    cfg_write;
    mul_op_t mul_op;
    logic    do_sum;
    logic    load_result;
  } sfd_cmd_t;

endpackage

>>> sv/sfd_ctrl.sv
module sfd_ctrl import sfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last_pixel,
  output logic     in_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sfd_cmd_t cmd
);

  localparam logic [3:0] ST_SETUP = 4'd0;
  localparam logic [3:0] ST_RUN   = 4'd1;
  localparam logic [3:0] ST_D1    = 4'd2;
  localparam logic [3:0] ST_D2    = 4'd3;
  localparam logic [3:0] ST_M_LL  = 4'd4;
  localparam logic [3:0] ST_M_NLO = 4'd5;
  localparam logic [3:0] ST_M_NHI = 4'd6;
  localparam logic [3:0] ST_M_NN  = 4'd7;
  localparam logic [3:0] ST_M_NK  = 4'd8;
  localparam logic [3:0] ST_SUM   = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0] state, state_next;
  logic       pix_acc, cfg_acc, load;

  assign cfg_ready = (state == ST_RUN);
  assign in_ready  = (state == ST_RUN) && !cfg_valid;
  assign pix_acc   = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign load      = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SETUP: state_next = ST_RUN;
      ST_RUN: begin
        if (cfg_acc) state_next = ST_SETUP;
        else if (pix_acc && last_pixel) state_next = ST_D1;
      end
      ST_D1:    state_next = ST_D2;
      ST_D2:    state_next = ST_M_LL;
      ST_M_LL:  state_next = ST_M_NLO;
      ST_M_NLO: state_next = ST_M_NHI;
      ST_M_NHI: state_next = ST_M_NN;
      ST_M_NN:  state_next = ST_M_NK;
      ST_M_NK:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_FIN;
      ST_FIN: begin
        if (load) state_next = ST_RUN;
      end
      default:  state_next = ST_SETUP;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.pix_accept  = pix_acc;
    cmd.cfg_write   = cfg_acc;
    cmd.do_sum      = (state == ST_SUM);
    cmd.load_result = load;
    unique case (state)
      ST_M_LL:  cmd.mul_op = MUL_LL;
      ST_M_NLO: cmd.mul_op = MUL_NLO;
      ST_M_NHI: cmd.mul_op = MUL_NHI;
      ST_M_NN:  cmd.mul_op = MUL_NN;
      ST_M_NK:  cmd.mul_op = MUL_NK;
      default:  cmd.mul_op = MUL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SETUP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

>>> sv/sfd_datapath.sv
module sfd_datapath import sfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sfd_cmd_t          cmd,
  input  cfg_idx_t          cfg_index,
  input  logic [DimW-1:0]   cfg_data,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              suspicious,
  output logic              mostly_dark,
  output logic              low_variance,
  output logic              dark_top_strip
);

  // dim / (3 * 2^(sh-13)) by reciprocal; 1 when dim is below the cap
  function automatic logic [StepW-1:0] step_of(logic [DimW-1:0] d, logic [DimW-1:0] cap,
                                              int sh);
    logic [25:0] p;
    logic [25:0] q;
    p = 26'(d) * 26'(RecipDiv);
    q = p >> sh;
    return (d >= cap) ? q[StepW-1:0] : StepW'(1);
  endfunction

  logic [DimW-1:0] frame_width, frame_height;
  logic [9:0]      dark_sum_limit;
  logic            cfg_hit, frame_clear;

  assign cfg_hit = cmd.cfg_write &&
                   (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT || cfg_index == CFG_DARK);
  assign frame_clear = cfg_hit || cmd.load_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= DimW'(640);
      frame_height   <= DimW'(480);
      dark_sum_limit <= 10'd24;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH:  frame_width    <= cfg_data;
        CFG_HEIGHT: frame_height   <= cfg_data;
        CFG_DARK:   dark_sum_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // derived frame geometry, refreshed every cycle
  logic [DimW-1:0]  w_c, h_c, w_eff, h_eff;
  logic [25:0]      h6_p;
  logic [9:0]       h6, top_c, top_rows;
  logic [11:0]      lower_c, lower_start;
  logic [24:0]      area;
  logic             area_zero, strip_ok;
  logic [StepW-1:0] grid_row_step, grid_col_step, strip_col_step;

  always_comb begin
    w_c     = (frame_width  > DimW'(MaxDim)) ? DimW'(MaxDim) : frame_width;
    h_c     = (frame_height > DimW'(MaxDim)) ? DimW'(MaxDim) : frame_height;
    h6_p    = (26'(h_c) * 26'(RecipDiv)) >> 14;
    h6      = h6_p[9:0];
    top_c   = (h6 > 10'(StripMinTop)) ? h6 : 10'(StripMinTop);
    lower_c = (h_c[12:1] > 12'(top_c)) ? h_c[12:1] : 12'(top_c);
  end

  always_ff @(posedge clk) begin
    w_eff          <= w_c;
    h_eff          <= h_c;
    area           <= 25'(w_c) * 25'(h_c);
    area_zero      <= (w_c == '0) || (h_c == '0);
    strip_ok       <= (h_c >= DimW'(StripMinH)) && (w_c >= DimW'(StripMinW));
    top_rows       <= top_c;
    lower_start    <= lower_c;
    grid_row_step  <= step_of(h_c, DimW'(GridRows), 16);
    grid_col_step  <= step_of(w_c, DimW'(GridCols), 17);
    strip_col_step <= step_of(w_c, DimW'(StripCols), 18);
  end

  // raster position
  logic [11:0]      column_pos;
  logic [12:0]      row_pos;
  logic [24:0]      pixel_total;
  logic [StepW-1:0] row_phase, gcol_phase, scol_phase;
  logic             counted, pix, row_end, is_top;

  assign counted = pixel_total < area;
  assign pix     = cmd.pix_accept && counted;
  assign row_end = (13'(column_pos) + 13'd1) >= w_eff;
  assign is_top  = row_pos < 13'(top_rows);

  always_ff @(posedge clk) begin
    if (rst || frame_clear) begin
      column_pos  <= '0;
      row_pos     <= '0;
      pixel_total <= '0;
      row_phase   <= '0;
      gcol_phase  <= '0;
      scol_phase  <= '0;
    end else if (pix) begin
      pixel_total <= pixel_total + 25'd1;
      if (row_end) begin
        column_pos <= '0;
        row_pos    <= row_pos + 13'd1;
        gcol_phase <= '0;
        scol_phase <= '0;
        row_phase  <= (row_phase + StepW'(1) == grid_row_step) ? '0 : row_phase + StepW'(1);
      end else begin
        column_pos <= column_pos + 12'd1;
        gcol_phase <= (gcol_phase + StepW'(1) == grid_col_step) ? '0 : gcol_phase + StepW'(1);
        scol_phase <= (scol_phase + StepW'(1) == strip_col_step) ? '0 : scol_phase + StepW'(1);
      end
    end
  end

  // stage 1: luma and classification
  logic             s1_valid, s1_dark, s1_grid, s1_top, s1_lower;
  logic [LumaW-1:0] s1_luma;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= pix;
    s1_luma  <= 18'(red) * 18'd299 + 18'(green) * 18'd587 + 18'(blue) * 18'd114;
    s1_dark  <= (10'(red) + 10'(green) + 10'(blue)) <= dark_sum_limit;
    s1_grid  <= (row_phase == '0) && (gcol_phase == '0);
    s1_top   <= (scol_phase == '0) && is_top;
    s1_lower <= (scol_phase == '0) && !is_top && (row_pos >= 13'(lower_start));
  end

  // stage 2: luma square; an item of a cleared frame is dropped here
  logic        s2_valid;
  logic [35:0] s2_sq;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid && s1_grid && !frame_clear;
    s2_sq <= 36'(s1_luma) * 36'(s1_luma);
  end

  // frame accumulators
  logic [12:0] grid_samples, grid_dark;
  logic [30:0] luma_sum;
  logic [48:0] luma_square_sum;
  logic [17:0] top_samples, top_dark;
  logic [18:0] lower_samples, lower_dark;

  always_ff @(posedge clk) begin
    if (rst || frame_clear) begin
      grid_samples    <= '0;
      grid_dark       <= '0;
      luma_sum        <= '0;
      luma_square_sum <= '0;
      top_samples     <= '0;
      top_dark        <= '0;
      lower_samples   <= '0;
      lower_dark      <= '0;
    end else begin
      if (s1_valid && s1_grid) begin
        grid_samples <= grid_samples + 13'd1;
        grid_dark    <= grid_dark + 13'(s1_dark);
        luma_sum     <= luma_sum + 31'(s1_luma);
      end
      if (s1_valid && s1_top) begin
        top_samples <= top_samples + 18'd1;
        top_dark    <= top_dark + 18'(s1_dark);
      end
      if (s1_valid && s1_lower) begin
        lower_samples <= lower_samples + 19'd1;
        lower_dark    <= lower_dark + 19'(s1_dark);
      end
      if (s2_valid) luma_square_sum <= luma_square_sum + 49'(s2_sq);
    end
  end

  // end of frame: shared 32x32 multiplier, one product per step
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [61:0] p_ll;
  logic [44:0] p_nlo;
  logic [29:0] p_nhi;
  logic [25:0] p_nn;
  logic [49:0] p_nk;
  logic [63:0] var_lhs, var_rhs;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_LL:  begin mul_a = 32'(luma_sum);     mul_b = 32'(luma_sum);               end
      MUL_NLO: begin mul_a = 32'(grid_samples); mul_b = luma_square_sum[31:0];       end
      MUL_NHI: begin mul_a = 32'(grid_samples); mul_b = 32'(luma_square_sum[48:32]); end
      MUL_NN:  begin mul_a = 32'(grid_samples); mul_b = 32'(grid_samples);           end
      MUL_NK:  begin mul_a = 32'(p_nn);         mul_b = VarLimitScaled;              end
      default: ;
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      MUL_LL:  p_ll  <= mul_p[61:0];
      MUL_NLO: p_nlo <= mul_p[44:0];
      MUL_NHI: p_nhi <= mul_p[29:0];
      MUL_NN:  p_nn  <= mul_p[25:0];
      MUL_NK:  p_nk  <= mul_p[49:0];
      default: ;
    endcase
    if (cmd.do_sum) begin
      var_lhs <= 64'(p_nlo) + {2'b00, p_nhi, 32'h0};
      var_rhs <= 64'(p_ll) + 64'(p_nk);
    end
  end

  logic complete, f_dark, f_var, f_strip;

  always_comb begin
    complete = !area_zero && (pixel_total >= area);
    f_dark   = complete && (grid_samples != '0) &&
               (17'(grid_dark) * 17'd10 >= 17'(grid_samples) * 17'd9);
    f_var    = complete && (grid_samples != '0) && (var_lhs < var_rhs);
    f_strip  = complete && strip_ok && (top_samples != '0) && (lower_samples != '0) &&
               (21'(top_dark) * 21'd5 >= 21'(top_samples) * 21'd4) &&
               (21'(lower_dark) * 21'd4 < 21'(lower_samples) * 21'd3);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      suspicious     <= f_dark || f_var || f_strip || area_zero;
      mostly_dark    <= f_dark;
      low_variance   <= f_var;
      dark_top_strip <= f_strip;
    end
  end

endmodule

>>> sv/suspicious_frame_detector_unit.sv
// Channel   Handshake                 Payload
// in        in_valid / in_ready       red, green, blue, last_pixel
// out       out_valid / out_ready     suspicious, mostly_dark, low_variance, dark_top_strip
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Pixels are taken one per cycle while a frame streams in and no register write is offered.
// The item marking frame end holds off input through the end-of-frame steps: two to drain the luma
// pipeline, five products on the shared 32x32 multiplier, one wide add, one load.
// A held result waits in the output register; input stays off until it can be loaded.
// After reset or a register write, input is held off for the setup state to refresh geometry.
`include "suspicious_frame_detector_unit_defines.svh"

module suspicious_frame_detector_unit import sfd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  input  logic            last_pixel,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            suspicious,
  output logic            mostly_dark,
  output logic            low_variance,
  output logic            dark_top_strip,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  cfg_idx_t        cfg_index,
  input  logic [DimW-1:0] cfg_data
);

  sfd_cmd_t cmd;

  sfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_pixel (last_pixel),
    .in_ready   (in_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  sfd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .suspicious     (suspicious),
    .mostly_dark    (mostly_dark),
    .low_variance   (low_variance),
    .dark_top_strip (dark_top_strip)
  );

  `SFD_ASSERT_NXT(a_last_stalls, in_valid && in_ready && last_pixel, !in_ready, "input open after frame end")
  `SFD_ASSERT_NXT(a_cfg_stalls, cfg_valid && cfg_ready, !in_ready, "input open right after cfg write")
  `SFD_ASSERT_IMP(a_flag_or, out_valid && (mostly_dark || low_variance || dark_top_strip), suspicious, "flag without suspicious")

endmodule

>>> test/suspicious_frame_detector_unit_tb.sv
module suspicious_frame_detector_unit_tb;
  import sfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 1000000;
  localparam int SettleCycles = 20;

  typedef enum {PAT_NOISE, PAT_DARK, PAT_FLAT, PAT_STRIP} pattern_t;

  typedef struct packed {
    logic suspicious;
    logic mostly_dark;
    logic low_variance;
    logic dark_top_strip;
  } frame_flags_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, last_pixel;
  logic [7:0] red, green, blue;
  logic out_valid, out_ready;
  logic suspicious, mostly_dark, low_variance, dark_top_strip;
  logic cfg_valid, cfg_ready;
  cfg_idx_t cfg_index;
  logic [DimW-1:0] cfg_data;

  suspicious_frame_detector_unit dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [12:0] width_reg, height_reg;
  logic [9:0] dark_limit;
  int unsigned row_step, col_step, strip_step;
  int unsigned col_pos, row_pos, pixel_count;
  longint unsigned n_grid, n_grid_dark, luma_acc, luma_sq_acc;
  longint unsigned n_top, n_top_dark, n_lower, n_lower_dark;

  frame_flags_t flags_due[$];
  int fails = 0;
  int unsigned cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic int unsigned clamp_dim(logic [12:0] v);
    return (v > MaxDim) ? MaxDim : int'(v);
  endfunction

  function automatic int unsigned grid_step(int unsigned dim, int unsigned cap);
    int unsigned d, s;
    d = (dim == 0) ? 1 : dim;
    s = (d < cap) ? d : cap;
    return (d / s < 1) ? 1 : d / s;
  endfunction

  function automatic void clear_frame();
    col_pos = 0; row_pos = 0; pixel_count = 0;
    n_grid = 0; n_grid_dark = 0; luma_acc = 0; luma_sq_acc = 0;
    n_top = 0; n_top_dark = 0; n_lower = 0; n_lower_dark = 0;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [12:0] data);
    case (idx)
      CFG_WIDTH: width_reg = data;
      CFG_HEIGHT: height_reg = data;
      CFG_DARK: dark_limit = data[9:0];
      default: return;
    endcase
    row_step = grid_step(clamp_dim(height_reg), GridRows);
    col_step = grid_step(clamp_dim(width_reg), GridCols);
    strip_step = grid_step(clamp_dim(width_reg), StripCols);
    clear_frame();
  endfunction

  function automatic void account_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic last);
    int unsigned w, h, area, top_rows, lower_start;
    bit dark, complete;
    longint unsigned luma;
    logic [127:0] lhs, rhs;
    frame_flags_t f;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    area = w * h;
    top_rows = (h / 6 > StripMinTop) ? h / 6 : StripMinTop;
    lower_start = (h / 2 > top_rows) ? h / 2 : top_rows;
    if (pixel_count < area) begin
      dark = (int'(r) + int'(g) + int'(b)) <= int'(dark_limit);
      if (row_pos % row_step == 0 && col_pos % col_step == 0) begin
        luma = 299 * r + 587 * g + 114 * b;
        n_grid++;
        if (dark) n_grid_dark++;
        luma_acc += luma;
        luma_sq_acc += luma * luma;
      end
      if (col_pos % strip_step == 0) begin
        if (row_pos < top_rows) begin
          n_top++;
          if (dark) n_top_dark++;
        end else if (row_pos >= lower_start) begin
          n_lower++;
          if (dark) n_lower_dark++;
        end
      end
      pixel_count++;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    end
    if (!last) return;
    f = '0;
    complete = area != 0 && pixel_count >= area;
    if (complete && n_grid != 0) begin
      lhs = 128'(n_grid) * 128'(luma_sq_acc);
      rhs = 128'(luma_acc) * 128'(luma_acc)
          + 128'(n_grid) * 128'(n_grid) * 128'(VarLimitScaled);
      f.mostly_dark = 10 * n_grid_dark >= 9 * n_grid;
      f.low_variance = lhs < rhs;
    end
    if (complete && h >= StripMinH && w >= StripMinW && n_top != 0 && n_lower != 0)
      f.dark_top_strip = (5 * n_top_dark >= 4 * n_top) && (4 * n_lower_dark < 3 * n_lower);
    f.suspicious = f.mostly_dark | f.low_variance | f.dark_top_strip | (area == 0);
    flags_due.push_back(f);
    clear_frame();
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    frame_flags_t e;
    if (!rst && out_valid && out_ready) begin
      if (flags_due.size() == 0) begin
        $error("result with no frame pending");
        fails++;
      end else begin
        e = flags_due.pop_front();
        if (suspicious !== e.suspicious) begin
          $error("suspicious: expected %b actual %b", e.suspicious, suspicious);
          fails++;
        end
        if (mostly_dark !== e.mostly_dark) begin
          $error("mostly_dark: expected %b actual %b", e.mostly_dark, mostly_dark);
          fails++;
        end
        if (low_variance !== e.low_variance) begin
          $error("low_variance: expected %b actual %b", e.low_variance, low_variance);
          fails++;
        end
        if (dark_top_strip !== e.dark_top_strip) begin
          $error("dark_top_strip: expected %b actual %b", e.dark_top_strip, dark_top_strip);
          fails++;
        end
      end
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_pixel(logic [23:0] rgb, logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    {red, green, blue} <= rgb;
    last_pixel <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    account_pixel(red, green, blue, last_pixel);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [12:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // input off, every result drained, then let the end-of-frame pipeline settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (flags_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_geometry(logic [12:0] w, logic [12:0] h, logic [12:0] lim);
    wait_quiet();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_DARK, lim);
  endtask

  function automatic logic [23:0] make_pixel(pattern_t pat, int unsigned idx,
                                             logic [23:0] base);
    int unsigned w, h, row, top_rows, part;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    row = (w == 0) ? 0 : idx / w;
    top_rows = (h / 6 > StripMinTop) ? h / 6 : StripMinTop;
    part = dark_limit / 3;
    if (part > 255) part = 255;
    case (pat)
      PAT_DARK:
        return {8'($urandom_range(part)), 8'($urandom_range(part)), 8'($urandom_range(part))};
      PAT_FLAT:
        return ($urandom_range(9) == 0) ? base ^ 24'h1 : base;
      PAT_STRIP:
        if (row < top_rows)
          return {8'($urandom_range(part)), 8'($urandom_range(part)), 8'($urandom_range(part))};
        else
          return 24'($urandom());
      default: return 24'($urandom());
    endcase
  endfunction

  // count pixels; last one carries the frame-end mark
  task automatic send_frame(pattern_t pat, int unsigned count);
    logic [23:0] base;
    base = 24'($urandom());
    for (int unsigned i = 0; i < count; i++)
      send_pixel(make_pixel(pat, i, base), i + 1 == count);
  endtask

  function automatic int unsigned frame_area();
    return clamp_dim(width_reg) * clamp_dim(height_reg);
  endfunction

  task automatic test_zero_dimension();
    set_geometry(13'd0, 13'd5, 13'd24);
    send_frame(PAT_NOISE, 2);
    set_geometry(13'd5, 13'd0, 13'd24);
    send_frame(PAT_NOISE, 1);
  endtask

  task automatic test_single_pixel();
    set_geometry(13'd1, 13'd1, 13'd0);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h000000, 1'b1);
    set_geometry(13'd1, 13'd1, 13'd765);
    send_pixel(24'hFFFFFF, 1'b1);
    set_geometry(13'd1, 13'd1, 13'd1023);
    send_pixel(24'h805A01, 1'b1);
  endtask

  task automatic test_short_and_extra();
    set_geometry(13'd4, 13'd3, 13'd24);
    send_frame(PAT_DARK, 5);
    send_frame(PAT_FLAT, 11);
    set_geometry(13'd3, 13'd2, 13'd300);
    send_frame(PAT_DARK, 9);
    send_frame(PAT_NOISE, 6);
  endtask

  task automatic test_dark_and_flat();
    set_geometry(13'd6, 13'd4, 13'd90);
    send_frame(PAT_DARK, frame_area());
    wait_quiet();
    send_frame(PAT_FLAT, frame_area());
    send_frame(PAT_NOISE, frame_area());
  endtask

  // strip-sized frames are long; short frames exercise the strip geometry
  task automatic test_top_strip();
    set_geometry(13'd48, 13'd24, 13'd60);
    send_frame(PAT_STRIP, 30);
    set_geometry(13'd47, 13'd24, 13'd60);
    send_frame(PAT_STRIP, 25);
    set_geometry(13'd96, 13'd23, 13'd60);
    send_frame(PAT_STRIP, 25);
  endtask

  task automatic test_oversize();
    set_geometry(13'd8191, 13'd1, 13'd24);
    send_frame(PAT_FLAT, 20);
    set_geometry(13'd1, 13'd4096, 13'd24);
    send_frame(PAT_NOISE, 20);
    wait_quiet();
    // unused index must leave geometry alone
    write_reg(CFG_UNUSED, 13'h1FFF);
    send_frame(PAT_DARK, 10);
  endtask

  task automatic test_random();
    int unsigned w, h, n, area;
    pattern_t pat;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 35 : 57) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 35 : 57) : 0;
      for (int k = 0; k < 3; k++) begin
        if (k == 0 || $urandom_range(1) == 0) begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 6);
          set_geometry(13'(w), 13'(h), 13'($urandom_range(1023)));
        end
        pat = pattern_t'($urandom_range(3));
        area = frame_area();
        n = $urandom_range(99);
        if (n < 8) n = $urandom_range(1, area);
        else if (n < 15) n = area + $urandom_range(1, 6);
        else n = area;
        send_frame(pat, n);
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    last_pixel = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    width_reg = 13'd640;
    height_reg = 13'd480;
    dark_limit = 10'd24;
    apply_reg(CFG_DARK, 13'd24);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_zero_dimension();
    test_single_pixel();
    test_short_and_extra();
    test_dark_and_flat();
    test_top_strip();
    test_oversize();
    test_random();
    wait_quiet();
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
